>>> design/otg_pkg.sv
// Package for the optical tremolo gain block: widths, register map, config
// struct, state codes and status struct shared by all modules.
// No dependencies.
package otg_pkg;

    localparam int PHASE_BITS  = 24;
    localparam int SAMPLE_BITS = 24;

    localparam int NUM_REGS = 7;
    localparam int ADDR_W   = $clog2(4 * NUM_REGS);
    localparam int DATA_W   = 32;
    localparam int TDATA_W  = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    localparam int COEF_W  = 16;
    localparam int ENV_W   = 16;
    localparam int DEPTH_W = 17;
    localparam int OGAIN_W = 16;
    localparam int G_W     = 17;

    // digit-serial multiplier geometry
    localparam int DIGIT_W    = 4;
    localparam int MUL_DIGITS = 5;
    localparam int MP_W       = DIGIT_W * MUL_DIGITS;
    localparam int MC_W       = SAMPLE_BITS + G_W;
    localparam int ACC_W      = MC_W + MP_W;
    localparam int CNT_W      = $clog2(MUL_DIGITS + 1);

    localparam int OUT_SHIFT = 30;
    localparam int P_W       = ACC_W - OUT_SHIFT;

    localparam logic [PHASE_BITS-1:0] RST_PHASE_INC = PHASE_BITS'(139810);
    localparam logic [DEPTH_W-1:0]    RST_DEPTH     = DEPTH_W'(32768);
    localparam logic [PHASE_BITS-1:0] RST_WIDTH     = '0;
    localparam logic [OGAIN_W-1:0]    RST_OUT_GAIN  = OGAIN_W'(16384);
    localparam logic [COEF_W-1:0]     RST_ATTACK    = COEF_W'(65399);
    localparam logic [COEF_W-1:0]     RST_RELEASE   = COEF_W'(65496);
    localparam logic                  RST_STEREO    = 1'b1;

    localparam logic [DEPTH_W-1:0] ONE_Q16 = DEPTH_W'(65536);

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase_inc;
        logic [DEPTH_W-1:0]    depth;
        logic [PHASE_BITS-1:0] width_off;
        logic [OGAIN_W-1:0]    out_gain;
        logic [COEF_W-1:0]     attack;
        logic [COEF_W-1:0]     release_c;
        logic                  stereo;
    } cfg_t;

    typedef enum logic [2:0] {
        REG_PHASE_INC,
        REG_DEPTH,
        REG_WIDTH,
        REG_OUT_GAIN,
        REG_ATTACK,
        REG_RELEASE,
        REG_STEREO
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ENV,
        ST_GAIN,
        ST_MAG,
        ST_OGN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } core_status_t;

endpackage

>>> design/otg_regs.sv
// APB register file for the optical tremolo gain block.
// Depends on otg_pkg.
module otg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [otg_pkg::ADDR_W-1:0]  paddr,
    input  logic [otg_pkg::DATA_W-1:0]  pwdata,
    output logic [otg_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output otg_pkg::cfg_t               cfg
);
    import otg_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PHASE_INC: cfg_next.phase_inc = pwdata[PHASE_BITS-1:0];
                REG_DEPTH:     cfg_next.depth     = pwdata[DEPTH_W-1:0];
                REG_WIDTH:     cfg_next.width_off = pwdata[PHASE_BITS-1:0];
                REG_OUT_GAIN:  cfg_next.out_gain  = pwdata[OGAIN_W-1:0];
                REG_ATTACK:    cfg_next.attack    = pwdata[COEF_W-1:0];
                REG_RELEASE:   cfg_next.release_c = pwdata[COEF_W-1:0];
                REG_STEREO:    cfg_next.stereo    = pwdata[0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PHASE_INC: prdata = DATA_W'(cfg_reg.phase_inc);
            REG_DEPTH:     prdata = DATA_W'(cfg_reg.depth);
            REG_WIDTH:     prdata = DATA_W'(cfg_reg.width_off);
            REG_OUT_GAIN:  prdata = DATA_W'(cfg_reg.out_gain);
            REG_ATTACK:    prdata = DATA_W'(cfg_reg.attack);
            REG_RELEASE:   prdata = DATA_W'(cfg_reg.release_c);
            REG_STEREO:    prdata = DATA_W'(cfg_reg.stereo);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.phase_inc <= RST_PHASE_INC;
            cfg_reg.depth     <= RST_DEPTH;
            cfg_reg.width_off <= RST_WIDTH;
            cfg_reg.out_gain  <= RST_OUT_GAIN;
            cfg_reg.attack    <= RST_ATTACK;
            cfg_reg.release_c <= RST_RELEASE;
            cfg_reg.stereo    <= RST_STEREO;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> design/otg_mul.sv
// Digit-serial unsigned multiplier, one 4-bit digit of the multiplier per
// cycle, MSB first. Depends on otg_pkg.
module otg_mul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [otg_pkg::MC_W-1:0]    mcand,
    input  logic [otg_pkg::MP_W-1:0]    mplier,
    output logic                        done,
    output logic [otg_pkg::ACC_W-1:0]   prod
);
    import otg_pkg::*;

    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic [MC_W-1:0]          mc_reg;
    logic [MP_W-1:0]          mp_reg;
    logic [MP_W-1:0]          mp_next;
    logic [CNT_W-1:0]         cnt_reg;
    logic [CNT_W-1:0]         cnt_next;
    logic                     busy_reg;
    logic                     busy_next;
    logic                     done_reg;
    logic                     done_next;
    logic [DIGIT_W-1:0]       digit;
    logic [MC_W+DIGIT_W-1:0]  partial;

    assign digit   = mp_reg[MP_W-1 -: DIGIT_W];
    assign partial = (MC_W+DIGIT_W)'(mc_reg) * (MC_W+DIGIT_W)'(digit);
    assign done    = done_reg;
    assign prod    = acc_reg;

    always_comb
    begin
        acc_next  = acc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            mp_next   = mplier;
            cnt_next  = CNT_W'(MUL_DIGITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg << DIGIT_W) + ACC_W'(partial);
            mp_next  = mp_reg << DIGIT_W;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mp_reg  <= mp_next;
        if (start)
        begin
            mc_reg <= mcand;
        end
    end

endmodule

>>> design/otg_ctrl.sv
// Sequencer for the tremolo: LFO phase, per-channel envelopes, gain and
// output scaling, all products through one otg_mul. Depends on otg_pkg, otg_mul.
module otg_ctrl (
    input  logic                             clk,
    input  logic                             rst_n,
    input  otg_pkg::cfg_t                    cfg,
    input  logic                             start,
    input  logic                             out_free,
    input  logic [otg_pkg::SAMPLE_BITS-1:0]  smp_l,
    input  logic [otg_pkg::SAMPLE_BITS-1:0]  smp_r,
    output logic [otg_pkg::SAMPLE_BITS-1:0]  res_l,
    output logic [otg_pkg::SAMPLE_BITS-1:0]  res_r,
    output otg_pkg::core_status_t            status
);
    import otg_pkg::*;

    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (OUT_SHIFT - 1);
    localparam logic [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [P_W-1:0] P_HI = P_W'(S_MAX);

    state_t                  state_reg;
    state_t                  state_next;
    logic                    ch_reg;
    logic                    ch_next;
    logic                    mstart_reg;
    logic                    mstart_next;
    logic [PHASE_BITS-1:0]   lfo_reg;
    logic [PHASE_BITS-1:0]   lfo_next;
    logic [ENV_W-1:0]        env_reg [2];
    logic [ENV_W-1:0]        env_next [2];
    logic [G_W-1:0]          g_reg;
    logic [G_W-1:0]          g_next;
    logic [SAMPLE_BITS-1:0]  res_reg [2];
    logic [SAMPLE_BITS-1:0]  res_next [2];

    logic [MC_W-1:0]         mcand;
    logic [MP_W-1:0]         mplier;
    logic                    mdone;
    logic [ACC_W-1:0]        prod;
    logic                    step_done;

    logic [PHASE_BITS-1:0]   phase_ch;
    logic                    drive;
    logic [ENV_W-1:0]        env_cur;
    logic [DEPTH_W-1:0]      env_mc;
    logic [ENV_W-1:0]        env_q;
    logic [ENV_W-1:0]        env_new;
    logic [DEPTH_W-1:0]      d_sat;
    logic [33:0]             gsum;
    logic [SAMPLE_BITS-1:0]  smp_ch;
    logic                    neg;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [ACC_W-1:0]        rnd;
    logic [P_W-1:0]          p;
    logic [SAMPLE_BITS-1:0]  sat_val;

    otg_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mstart_reg),
        .mcand  (mcand),
        .mplier (mplier),
        .done   (mdone),
        .prod   (prod)
    );

    assign step_done = mdone && !mstart_reg;

    // channel operands
    assign phase_ch = ch_reg ? (lfo_reg + cfg.width_off) : lfo_reg;
    assign drive    = (phase_ch != '0) && !phase_ch[PHASE_BITS-1];
    assign env_cur  = env_reg[ch_reg];
    assign env_mc   = drive ? (ONE_Q16 - DEPTH_W'(env_cur)) : DEPTH_W'(env_cur);
    assign env_q    = prod[31:16];
    // 65536 - deficit, with a zero deficit saturating to 65535
    assign env_new  = drive ? ((env_q == '0) ? '1 : (ENV_W'(0) - env_q)) : env_q;
    assign d_sat    = (cfg.depth > ONE_Q16) ? ONE_Q16 : cfg.depth;
    assign gsum     = 34'({ONE_Q16 - d_sat, 16'h0000}) + 34'(prod[32:0]) + 34'(32768);
    assign smp_ch   = ch_reg ? smp_r : smp_l;
    assign neg      = smp_ch[SAMPLE_BITS-1];
    assign mag      = neg ? (SAMPLE_BITS'(0) - smp_ch) : smp_ch;
    assign rnd      = prod + RND;
    assign p        = rnd[ACC_W-1:OUT_SHIFT];

    always_comb
    begin
        if (neg)
        begin
            sat_val = (p > P_HI + P_W'(1)) ? S_MIN
                                           : (SAMPLE_BITS'(0) - p[SAMPLE_BITS-1:0]);
        end
        else
        begin
            sat_val = (p > P_HI) ? S_MAX : p[SAMPLE_BITS-1:0];
        end
    end

    always_comb
    begin
        case (state_reg)
            ST_ENV:
            begin
                mcand  = MC_W'(env_mc);
                mplier = MP_W'(drive ? cfg.attack : cfg.release_c);
            end
            ST_GAIN:
            begin
                mcand  = MC_W'(d_sat);
                mplier = MP_W'(env_cur);
            end
            ST_MAG:
            begin
                mcand  = MC_W'(mag);
                mplier = MP_W'(g_reg);
            end
            default:
            begin
                mcand  = prod[MC_W-1:0];
                mplier = MP_W'(cfg.out_gain);
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        ch_next       = ch_reg;
        mstart_next   = 1'b0;
        lfo_next      = lfo_reg;
        env_next      = env_reg;
        g_next        = g_reg;
        res_next      = res_reg;
        status.idle      = 1'b0;
        status.res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                status.idle = 1'b1;
                if (start)
                begin
                    ch_next     = 1'b0;
                    state_next  = ST_ENV;
                    mstart_next = 1'b1;
                end
            end
            ST_ENV:
            begin
                if (step_done)
                begin
                    env_next[ch_reg] = env_new;
                    state_next       = ST_GAIN;
                    mstart_next      = 1'b1;
                end
            end
            ST_GAIN:
            begin
                if (step_done)
                begin
                    g_next      = gsum[32:16];
                    state_next  = ST_MAG;
                    mstart_next = 1'b1;
                end
            end
            ST_MAG:
            begin
                if (step_done)
                begin
                    state_next  = ST_OGN;
                    mstart_next = 1'b1;
                end
            end
            ST_OGN:
            begin
                if (step_done)
                begin
                    res_next[ch_reg] = sat_val;
                    if (!ch_reg && cfg.stereo)
                    begin
                        ch_next     = 1'b1;
                        state_next  = ST_ENV;
                        mstart_next = 1'b1;
                    end
                    else
                    begin
                        // mono: right sample passes untouched
                        if (!ch_reg)
                        begin
                            res_next[1] = smp_r;
                        end
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    status.res_valid = 1'b1;
                    lfo_next         = lfo_reg + cfg.phase_inc;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_l = res_reg[0];
    assign res_r = res_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ch_reg     <= 1'b0;
            mstart_reg <= 1'b0;
            lfo_reg    <= '0;
            env_reg[0] <= '0;
            env_reg[1] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ch_reg     <= ch_next;
            mstart_reg <= mstart_next;
            lfo_reg    <= lfo_next;
            env_reg    <= env_next;
        end
    end

    always_ff @(posedge clk)
    begin
        g_reg   <= g_next;
        res_reg <= res_next;
    end

endmodule

>>> design/optical_tremolo_gain_top.sv
// Top level of the optical tremolo gain block: stream ports, input capture,
// output register. Depends on otg_pkg, otg_regs, otg_ctrl.
//
// Stereo photo-cell tremolo: each item is one stereo sample pair; each result
// is the pair scaled by the LFO-driven envelope gain and the output gain,
// saturated to 24 bits. An item is taken only while the sequencer is idle;
// each channel processed (both in stereo mode, only the left in mono) needs
// four products (envelope, gain, sample, output gain) from one shared
// multiplier that consumes a 4-bit digit per cycle, five digits a product.
// A finished pair sits in the output register, so the next item is accepted
// while it waits to be taken. The user must write registers through the APB
// port only while no item is in flight; the block itself does not enforce it.
module optical_tremolo_gain_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // fields from bit 0 up: sample_left, sample_right
    input  logic [otg_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // fields from bit 0 up: out_left, out_right
    output logic [otg_pkg::TDATA_W-1:0]   m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [otg_pkg::ADDR_W-1:0]    paddr,
    input  logic [otg_pkg::DATA_W-1:0]    pwdata,
    output logic [otg_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);
    import otg_pkg::*;

    cfg_t                    cfg;
    core_status_t            status;
    logic                    accept;
    logic                    out_free;
    logic [SAMPLE_BITS-1:0]  smp_l_reg;
    logic [SAMPLE_BITS-1:0]  smp_r_reg;
    logic [SAMPLE_BITS-1:0]  res_l;
    logic [SAMPLE_BITS-1:0]  res_r;
    logic [SAMPLE_BITS-1:0]  out_l_reg;
    logic [SAMPLE_BITS-1:0]  out_r_reg;
    logic                    m_valid_reg;
    logic                    m_valid_next;

    otg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    otg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .start    (accept),
        .out_free (out_free),
        .smp_l    (smp_l_reg),
        .smp_r    (smp_r_reg),
        .res_l    (res_l),
        .res_r    (res_r),
        .status   (status)
    );

    assign s_tready = status.idle;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = TDATA_W'({out_r_reg, out_l_reg});

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (status.res_valid)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            smp_l_reg <= s_tdata[SAMPLE_BITS-1:0];
            smp_r_reg <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
        end
        if (status.res_valid)
        begin
            out_l_reg <= res_l;
            out_r_reg <= res_r;
        end
    end

endmodule
